// File: rtl/multi_stack_shared_pool_unit_defines.svh
// Assertion macros shared by the RTL of the multi-stack shared pool unit.
// Each takes a label, an antecedent, a consequent and a message string.
`ifndef MULTI_STACK_SHARED_POOL_UNIT_DEFINES_SVH
`define MULTI_STACK_SHARED_POOL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mssp_pkg.sv
package mssp_pkg;

  localparam int NUM_STACKS = 4;
  localparam int NUM_SLOTS  = 16;

  // A pointer also holds the null code NUM_SLOTS.
  localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
  localparam int ADDR_W = $clog2(NUM_SLOTS);
  localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(NUM_SLOTS);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef struct packed {
    logic               kind;
    logic [1:0]         stack_select;
    logic signed [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] data_out;
  } out_item_t;

  // Access bundle from the control logic to the slot pool.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PTR_W-1:0]  wr_link;
    logic              wr_data_en;
    logic [31:0]       wr_data;
  } pool_req_t;

  function automatic logic ptr_valid(logic [PTR_W-1:0] p);
    return int'(p) < NUM_SLOTS;
  endfunction

  // Link of a slot never written since reset: the next slot, null after the last.
  function automatic logic [PTR_W-1:0] link_init(logic [ADDR_W-1:0] a);
    return PTR_W'(a) + PTR_W'(1);
  endfunction

endpackage

// File: rtl/mssp_pool.sv
module mssp_pool import mssp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pool_req_t        req_i,
  output logic [PTR_W-1:0] rd_link_o,
  output logic [31:0]      rd_data_o
);

  logic [31:0]      data_mem [NUM_SLOTS];
  logic [PTR_W-1:0] link_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] link_vld_q;
  logic [PTR_W-1:0] rd_link_q;
  logic [31:0]      rd_data_q;

  // Mark links as written; unwritten links read as the initial chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (req_i.wr_en) begin
      link_vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      link_mem[req_i.wr_addr] <= req_i.wr_link;
    end
    if (req_i.wr_en && req_i.wr_data_en) begin
      data_mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_link_q <= link_vld_q[req_i.rd_addr] ? link_mem[req_i.rd_addr]
                                             : link_init(req_i.rd_addr);
      rd_data_q <= data_mem[req_i.rd_addr];
    end
  end

  assign rd_link_o = rd_link_q;
  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/multi_stack_shared_pool_unit.sv
// An accepted item's operands are registered with the state at the accepting edge, and
// the result and done_o are registered at the end of the execute state.
// An item is taken only while idle: busy_o stays high in the execute state, which uses
// the slot's link read from the slot pool memory and writes the slot back.
// Reset: asynchronous, active low; all stacks empty, free chain covers every slot,
// restored by per-slot valid bits with no clearing pass. The receiver cannot stall.
module multi_stack_shared_pool_unit import mssp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  item_i,
  output logic      busy_o,
  output logic      done_o,
  output out_item_t result_o
);

`include "multi_stack_shared_pool_unit_defines.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // Stack tops and free-list head live in flops; the slots in the pool memory.
  logic [PTR_W-1:0] stack_head_q [NUM_STACKS];
  logic [PTR_W-1:0] stack_head_d [NUM_STACKS];
  logic [PTR_W-1:0] free_head_q, free_head_d;

  // Item held across the read cycle.
  logic             kind_q;
  logic [STK_W-1:0] idx_q;
  logic [31:0]      data_q;
  logic [PTR_W-1:0] slot_q;
  logic             fail_q;

  logic             accept;
  logic [STK_W-1:0] idx;
  logic             sel_ok;
  logic [PTR_W-1:0] slot;
  logic             fail;

  pool_req_t        pool_req;
  logic [PTR_W-1:0] rd_link;
  logic [31:0]      rd_data;

  logic      done_q;
  out_item_t result_q, result_d;

  assign busy_o = (state_q == S_EXEC);
  assign accept = start_i && !busy_o;

  // Pick the slot to work on: free head for a push, the stack top for a pop.
  always_comb begin
    idx    = STK_W'(item_i.stack_select);
    sel_ok = int'(item_i.stack_select) < NUM_STACKS;
    slot   = (item_i.kind == KIND_PUSH) ? free_head_q : stack_head_q[idx];
    fail   = !sel_ok || !ptr_valid(slot);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= item_i.kind;
      idx_q  <= idx;
      data_q <= item_i.data_in;
      slot_q <= slot;
      fail_q <= fail;
    end
  end

  // Read the slot's link and data on accept; write back in the execute cycle.
  always_comb begin
    pool_req            = '0;
    pool_req.rd_en      = accept && !fail;
    pool_req.rd_addr    = ADDR_W'(slot);
    pool_req.wr_addr    = ADDR_W'(slot_q);
    pool_req.wr_data    = data_q;
    pool_req.wr_link    = (kind_q == KIND_PUSH) ? stack_head_q[idx_q] : free_head_q;
    pool_req.wr_en      = busy_o && !fail_q;
    pool_req.wr_data_en = (kind_q == KIND_PUSH);
  end

  mssp_pool u_pool (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (pool_req),
    .rd_link_o (rd_link),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d      = state_q;
    stack_head_d = stack_head_q;
    free_head_d  = free_head_q;
    result_d     = result_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d           = S_IDLE;
        result_d.data_out = '0;
        if (fail_q) begin
          result_d.status = (kind_q == KIND_PUSH) ? ST_OVERFLOW : ST_EMPTY;
        end else begin
          result_d.status = ST_OK;
          if (kind_q == KIND_PUSH) begin
            // Advance the free list, link the slot over the old top.
            free_head_d         = rd_link;
            stack_head_d[idx_q] = slot_q;
          end else begin
            // Drop the top, hand the slot back to the free list.
            stack_head_d[idx_q] = rd_link;
            free_head_d         = slot_q;
            result_d.data_out   = rd_data;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      done_q      <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_head_q[i] <= PTR_NULL;
      end
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      stack_head_q <= stack_head_d;
      done_q       <= busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `MSSP_ASSERT_NEXT(a_accept_busy, accept, busy_o, "accepted item did not start")
  `MSSP_ASSERT_NEXT(a_exec_done, busy_o, done_o && !busy_o, "result not delivered")
  `MSSP_ASSERT_NOW(a_fail_zero, done_o && result_o.status != ST_OK,
                   result_o.data_out == '0, "failed item returned data")
  `MSSP_ASSERT_NOW(a_pool_port, 1'b1, !(pool_req.rd_en && pool_req.wr_en),
                   "pool read and write overlap")
  `MSSP_ASSERT_NOW(a_free_range, 1'b1, int'(free_head_q) <= NUM_SLOTS,
                   "free head out of range")

endmodule
